// File: hdl/int8_matmul_saturate_lut_activation_macros.svh
// Assertion macros for the int8 matrix multiply block.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef INT8_MATMUL_SATURATE_LUT_ACTIVATION_MACROS_SVH
`define INT8_MATMUL_SATURATE_LUT_ACTIVATION_MACROS_SVH

// Same-cycle implication, disabled during reset
`define I8MM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define I8MM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: hdl/i8mm_pkg.sv
// Shared types and constants for the int8 matrix multiply block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package i8mm_pkg;

	// Configuration register layout
	localparam int CFG_W     = 7;
	localparam int REG_IDX_W = 2;
	typedef logic [CFG_W-1:0]     cfg_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_ROWS  = 2'd0;
	localparam reg_idx_t REG_COLS  = 2'd1;
	localparam reg_idx_t REG_DEPTH = 2'd2;
	localparam cfg_t     CFG_RESET = 7'd48;

	// Input item kinds
	localparam logic [1:0] KIND_TBL  = 2'd0;
	localparam logic [1:0] KIND_WGT  = 2'd1;
	localparam logic [1:0] KIND_ELEM = 2'd2;

	// Column accumulators
	localparam int SUM_W = 22;
	typedef logic signed [SUM_W-1:0] sum_t;

	localparam sum_t SAT_HI  = 22'sd127;
	localparam sum_t SAT_LO  = -22'sd128;
	localparam int   TBL_OFS = 128;

	// Widest output row the result fields can address
	localparam int OUT_LIMIT = 64;

endpackage

// File: hdl/int8_matmul_saturate_lut_activation.sv
// Int8 matrix multiply with per-column accumulation, saturation and table lookup.
// Depends on i8mm_pkg and int8_matmul_saturate_lut_activation_macros.svh.
//
// Channel | Signals                                       | Direction
// in      | in_valid in_ready kind row_pos col_pos value  | item into block
// out     | out_valid out_ready row_index col_index       | result out of block
//         | out_value last                                |
// cfg     | cfg_valid cfg_ready cfg_index cfg_data        | register write
//
// A table or weight load leaves the sequencer idle. A row element runs the MAC
// step, where one shared 8x8 multiply-accumulate walks the columns, one per
// cycle, through the single read port of the accumulator memory; a drain step
// follows. The element that closes a row then steps each column through
// accumulator read, table read and output load. Output stalls hold the sequencer
// in the load step. Reset is asynchronous; accumulators read as zero after reset
// through per-column valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps

`include "int8_matmul_saturate_lut_activation_macros.svh"

module int8_matmul_saturate_lut_activation
	import i8mm_pkg::*;
#(
	parameter int MAX_ROWS  = 64,
	parameter int MAX_COLS  = 64,
	parameter int MAX_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           kind,
	input  logic [7:0]           row_pos,
	input  logic [5:0]           col_pos,
	input  logic signed [7:0]    value,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [5:0]           row_index,
	output logic [5:0]           col_index,
	output logic signed [7:0]    out_value,
	output logic                 last,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Derived sizes
	localparam int NCOL  = (MAX_COLS < OUT_LIMIT) ? MAX_COLS : OUT_LIMIT;
	localparam int CW    = (NCOL > 1) ? $clog2(NCOL) : 1;
	localparam int RMAX  = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int RW    = (RMAX > 1) ? $clog2(RMAX) : 1;
	localparam int DW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int WCW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int WDEP  = MAX_DEPTH * MAX_COLS;
	localparam int AW    = (WDEP > 1) ? $clog2(WDEP) : 1;

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAC   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_ERD   = 3'd3;
	localparam logic [2:0] ST_ESAT  = 3'd4;
	localparam logic [2:0] ST_ELOAD = 3'd5;

	logic [2:0]       state_q;
	logic [CW-1:0]    j_q;
	logic [RW-1:0]    row_q;
	cfg_t             row_count_q, col_count_q, inner_len_q;
	cfg_t             rows_eff, cols_eff, depth_eff;

	logic [DW-1:0]    pos_q;
	logic signed [7:0] val_q;
	logic             close_q;

	logic             mac_s1;
	logic [CW-1:0]    col_s1;
	logic [NCOL-1:0]  sum_vld_q;
	logic             sum_vld_s1;
	sum_t             sum_rd_s1;
	logic signed [7:0] wgt_rd_s1;
	logic [7:0]       tbl_rd_q;

	logic             out_vld_q;
	logic [5:0]       row_index_q, col_index_q;
	logic [7:0]       out_value_q;
	logic             last_q;

	logic             in_acc, elem_ok, elem_close, tbl_we, wgt_we;
	logic             last_col, out_load;
	logic [AW-1:0]    wgt_waddr, wgt_raddr;
	sum_t             sum_cur, sum_new;
	logic signed [15:0] prod;
	logic signed [7:0] sat_val;
	logic [7:0]       tbl_idx;

	// Memories
	logic [7:0]       tbl_mem [256];
	logic [7:0]       wgt_mem [WDEP];
	sum_t             sum_mem [NCOL];

	// Clamp register values to their usable ranges
	always_comb begin
		if (row_count_q == '0) rows_eff = CFG_W'(1);
		else if (int'(row_count_q) > RMAX) rows_eff = CFG_W'(RMAX);
		else rows_eff = row_count_q;

		if (col_count_q == '0) cols_eff = CFG_W'(1);
		else if (int'(col_count_q) > NCOL) cols_eff = CFG_W'(NCOL);
		else cols_eff = col_count_q;

		if (inner_len_q == '0) depth_eff = CFG_W'(1);
		else if (int'(inner_len_q) > MAX_DEPTH) depth_eff = CFG_W'(MAX_DEPTH);
		else depth_eff = inner_len_q;
	end

	// Decode the accepted transaction
	assign in_ready   = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign in_acc     = in_valid && in_ready;
	assign tbl_we     = in_acc && (kind == KIND_TBL);
	assign wgt_we     = in_acc && (kind == KIND_WGT)
		&& (int'(row_pos) < MAX_DEPTH) && (int'(col_pos) < MAX_COLS);
	assign elem_ok    = in_acc && (kind == KIND_ELEM) && (int'(row_pos) < int'(depth_eff));
	assign elem_close = (int'(row_pos) == int'(depth_eff) - 1);

	// Weight addresses: row-major, MAX_COLS entries per row
	assign wgt_waddr = AW'(DW'(row_pos)) * AW'(MAX_COLS) + AW'(WCW'(col_pos));
	assign wgt_raddr = AW'(pos_q) * AW'(MAX_COLS) + AW'(j_q);

	// Shared multiply-accumulate on the column read last cycle
	assign sum_cur = sum_vld_s1 ? sum_rd_s1 : '0;
	assign prod    = val_q * wgt_rd_s1;
	assign sum_new = sum_cur + {{(SUM_W-16){prod[15]}}, prod};

	// Saturate the column sum and form the table index
	always_comb begin
		if (sum_cur > SAT_HI) sat_val = 8'(SAT_HI);
		else if (sum_cur < SAT_LO) sat_val = 8'(SAT_LO);
		else sat_val = 8'(sum_cur);
		tbl_idx = 8'(sat_val) + 8'(TBL_OFS);
	end

	assign last_col = (int'(j_q) == int'(cols_eff) - 1);
	assign out_load = (state_q == ST_ELOAD) && (!out_vld_q || out_ready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= CFG_RESET;
			col_count_q <= CFG_RESET;
			inner_len_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROWS:  row_count_q <= cfg_data;
				REG_COLS:  col_count_q <= cfg_data;
				REG_DEPTH: inner_len_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Sequencer, column counter, row counter and accumulator valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			j_q       <= '0;
			row_q     <= '0;
			mac_s1    <= 1'b0;
			sum_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			mac_s1 <= (state_q == ST_MAC);
			if (mac_s1) sum_vld_q[col_s1] <= 1'b1;
			if (out_load) out_vld_q <= 1'b1;
			else if (out_valid && out_ready) out_vld_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (elem_ok) begin
						state_q <= ST_MAC;
						j_q     <= '0;
					end
				end
				ST_MAC: begin
					if (last_col) begin
						state_q <= ST_DRAIN;
						j_q     <= '0;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= close_q ? ST_ERD : ST_IDLE;
				end
				ST_ERD: begin
					state_q <= ST_ESAT;
				end
				ST_ESAT: begin
					state_q <= ST_ELOAD;
				end
				ST_ELOAD: begin
					if (out_load) begin
						if (last_col) begin
							// Close the row: clear sums, advance the row counter
							state_q   <= ST_IDLE;
							j_q       <= '0;
							sum_vld_q <= '0;
							if (int'(row_q) + 1 >= int'(rows_eff)) row_q <= '0;
							else row_q <= row_q + 1'b1;
						end else begin
							state_q <= ST_ERD;
							j_q     <= j_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Element and pipeline payload
	always_ff @(posedge clk) begin
		if (elem_ok) begin
			pos_q   <= DW'(row_pos);
			val_q   <= value;
			close_q <= elem_close;
		end
		col_s1     <= j_q;
		sum_vld_s1 <= sum_vld_q[j_q];
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			row_index_q <= 6'(row_q);
			col_index_q <= 6'(j_q);
			out_value_q <= tbl_rd_q;
			last_q      <= last_col;
		end
	end

	// Activation table memory
	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[row_pos] <= value;
		tbl_rd_q <= tbl_mem[tbl_idx];
	end

	// Weight memory
	always_ff @(posedge clk) begin
		if (wgt_we) wgt_mem[wgt_waddr] <= value;
		wgt_rd_s1 <= wgt_mem[wgt_raddr];
	end

	// Column accumulator memory
	always_ff @(posedge clk) begin
		if (mac_s1) sum_mem[col_s1] <= sum_new;
		sum_rd_s1 <= sum_mem[j_q];
	end

	assign out_valid = out_vld_q;
	assign row_index = row_index_q;
	assign col_index = col_index_q;
	assign out_value = out_value_q;
	assign last      = last_q;

	// Checks on the sequencer
	`I8MM_ASSERT_IMP(a_last_col, out_valid && last, int'(col_index) == int'(cols_eff) - 1)
	`I8MM_ASSERT_IMP(a_mac_in_seq, mac_s1, state_q == ST_MAC || state_q == ST_DRAIN)
	`I8MM_ASSERT_NXT(a_row_clear, out_load && last_col, sum_vld_q == '0 && state_q == ST_IDLE)

endmodule

// File: bench/tb_int8_matmul_saturate_lut_activation.sv
// Self-checking bench for the int8 matrix multiply with saturation and table lookup.
// Depends on i8mm_pkg and the int8_matmul_saturate_lut_activation top level; it predicts
// every column result from its own copy of the tables and sums and checks each transaction.
`timescale 1ns / 1ps

module tb_int8_matmul_saturate_lut_activation;
	import i8mm_pkg::*;

	localparam int MAX_ROWS      = 64;
	localparam int MAX_COLS      = 64;
	localparam int MAX_DEPTH     = 64;
	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 3 * OUT_LIMIT + 16;
	localparam int ITEM_GOAL     = 260;
	localparam int CYCLE_LIMIT   = 10_000_000;
	localparam int DIR_STEPS     = 26;
	localparam int WRAP_REPEATS  = 256;

	// Unused item kind, ignored by the block
	localparam logic [1:0] KIND_NONE = 2'd3;

	typedef enum logic {STEP_ITEM, STEP_CFG} step_op_e;
	typedef enum int {VAL_SMALL, VAL_FULL, VAL_EDGE} val_mode_e;

	typedef struct packed {
		logic [5:0]        row;
		logic [5:0]        col;
		logic signed [7:0] val;
		logic              last;
	} lut_result_t;

	typedef struct packed {
		step_op_e          op;
		logic [1:0]        knd;
		logic [7:0]        pos;
		logic [5:0]        col;
		logic signed [7:0] val;
		reg_idx_t          ridx;
		cfg_t              rdata;
		logic              has_exp;
		logic signed [7:0] exp_val;
	} dir_step_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [1:0]           kind      = '0;
	logic [7:0]           row_pos   = '0;
	logic [5:0]           col_pos   = '0;
	logic signed [7:0]    value     = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [5:0]           row_index;
	logic [5:0]           col_index;
	logic signed [7:0]    out_value;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Predictor state
	logic signed [7:0] act_table [256];
	logic signed [7:0] weight_mem [MAX_DEPTH][MAX_COLS];
	sum_t              col_sums [MAX_COLS];
	int                row_ctr   = 0;
	cfg_t              rows_reg  = CFG_RESET;
	cfg_t              cols_reg  = CFG_RESET;
	cfg_t              depth_reg = CFG_RESET;
	lut_result_t       pending_activations [$];

	// Bench bookkeeping
	int unsigned cycle_count     = 0;
	int          fail_count      = 0;
	int          effective_items = 0;
	int          burst_left      = 0;
	int          stall_mode      = 0;
	int          stall_left      = 0;
	bit          in_held         = 1'b0;
	bit          block_quiet     = 1'b0;

	// Directed stimulus; typed expectations only where the table entry is obvious
	dir_step_t directed [DIR_STEPS] = '{
		'{STEP_CFG,  KIND_TBL,  8'd0,   6'd0,  8'sd0,    REG_ROWS,  7'd1,   1'b0, 8'sd0},
		'{STEP_CFG,  KIND_TBL,  8'd0,   6'd0,  8'sd0,    REG_COLS,  7'd1,   1'b0, 8'sd0},
		'{STEP_CFG,  KIND_TBL,  8'd0,   6'd0,  8'sd0,    REG_DEPTH, 7'd1,   1'b0, 8'sd0},
		'{STEP_ITEM, KIND_TBL,  8'd255, 6'd0,  8'sd17,   REG_ROWS,  7'd0,   1'b0, 8'sd0},
		'{STEP_ITEM, KIND_TBL,  8'd0,   6'd63, -8'sd99,  REG_ROWS,  7'd0,   1'b0, 8'sd0},
		'{STEP_ITEM, KIND_TBL,  8'd128, 6'd0,  8'sd55,   REG_ROWS,  7'd0,   1'b0, 8'sd0},
		'{STEP_ITEM, KIND_WGT,  8'd0,   6'd0,  8'sd127,  REG_ROWS,  7'd0,   1'b0, 8'sd0},
		'{STEP_ITEM, KIND_ELEM, 8'd0,   6'd0,  8'sd127,  REG_ROWS,  7'd0,   1'b1, 8'sd17},
		'{STEP_ITEM, KIND_ELEM, 8'd0,   6'd0,  -8'sd128, REG_ROWS,  7'd0,   1'b1, -8'sd99},
		'{STEP_ITEM, KIND_ELEM, 8'd0,   6'd0,  8'sd0,    REG_ROWS,  7'd0,   1'b1, 8'sd55},
		'{STEP_ITEM, KIND_WGT,  8'd0,   6'd0,  -8'sd128, REG_ROWS,  7'd0,   1'b0, 8'sd0},
		'{STEP_ITEM, KIND_ELEM, 8'd0,   6'd0,  -8'sd128, REG_ROWS,  7'd0,   1'b1, 8'sd17},
		'{STEP_ITEM, KIND_WGT,  8'd64,  6'd0,  8'sd5,    REG_ROWS,  7'd0,   1'b0, 8'sd0},
		'{STEP_ITEM, KIND_ELEM, 8'd0,   6'd0,  8'sd1,    REG_ROWS,  7'd0,   1'b1, -8'sd99},
		'{STEP_ITEM, KIND_NONE, 8'd0,   6'd0,  8'sd127,  REG_ROWS,  7'd0,   1'b0, 8'sd0},
		'{STEP_ITEM, KIND_ELEM, 8'd1,   6'd0,  8'sd127,  REG_ROWS,  7'd0,   1'b0, 8'sd0},
		'{STEP_ITEM, KIND_ELEM, 8'd255, 6'd0,  -8'sd1,   REG_ROWS,  7'd0,   1'b0, 8'sd0},
		'{STEP_CFG,  KIND_TBL,  8'd0,   6'd0,  8'sd0,    REG_DEPTH, 7'd0,   1'b0, 8'sd0},
		'{STEP_ITEM, KIND_ELEM, 8'd0,   6'd0,  -8'sd1,   REG_ROWS,  7'd0,   1'b1, 8'sd17},
		'{STEP_CFG,  KIND_TBL,  8'd0,   6'd0,  8'sd0,    REG_COLS,  7'd127, 1'b0, 8'sd0},
		'{STEP_CFG,  KIND_TBL,  8'd0,   6'd0,  8'sd0,    REG_DEPTH, 7'd2,   1'b0, 8'sd0},
		'{STEP_ITEM, KIND_ELEM, 8'd0,   6'd0,  8'sd100,  REG_ROWS,  7'd0,   1'b0, 8'sd0},
		'{STEP_CFG,  KIND_TBL,  8'd0,   6'd0,  8'sd0,    REG_COLS,  7'd3,   1'b0, 8'sd0},
		'{STEP_CFG,  KIND_TBL,  8'd0,   6'd0,  8'sd0,    REG_ROWS,  7'd127, 1'b0, 8'sd0},
		'{STEP_ITEM, KIND_ELEM, 8'd1,   6'd0,  -8'sd100, REG_ROWS,  7'd0,   1'b0, 8'sd0},
		'{STEP_ITEM, KIND_ELEM, 8'd1,   6'd0,  8'sd1,    REG_ROWS,  7'd0,   1'b0, 8'sd0}
	};

	int8_matmul_saturate_lut_activation #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.MAX_DEPTH (MAX_DEPTH)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.row_pos   (row_pos),
		.col_pos   (col_pos),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_index (row_index),
		.col_index (col_index),
		.out_value (out_value),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Map a register value to the size it acts as: zero acts as one, above max as max
	function automatic int clamp_cfg(cfg_t v, int hi);
		if (v == 0)
			return 1;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic logic signed [7:0] pick_value(val_mode_e mode);
		int r;
		case (mode)
			VAL_SMALL: r = int'($urandom_range(0, 8)) - 4;
			VAL_EDGE:  r = $urandom_range(0, 1) ? 127 : -128;
			default:   r = int'($urandom_range(0, 255));
		endcase
		return r[7:0];
	endfunction

	// Apply one transaction to the predictor; queue the activations it closes.
	// Return 1 when the item changes state, 0 when the block ignores it.
	function automatic bit predict_activations(logic [1:0] k, logic [7:0] pos,
			logic [5:0] col, logic signed [7:0] v);
		int         ncols;
		int         ndepth;
		int         nrows;
		int         sat;
		logic [7:0] slot;
		ncols  = clamp_cfg(cols_reg, (MAX_COLS < OUT_LIMIT) ? MAX_COLS : OUT_LIMIT);
		ndepth = clamp_cfg(depth_reg, MAX_DEPTH);
		nrows  = clamp_cfg(rows_reg, MAX_ROWS);
		case (k)
			KIND_TBL: begin
				act_table[pos] = v;
				return 1'b1;
			end
			KIND_WGT: begin
				if (pos >= MAX_DEPTH || col >= MAX_COLS)
					return 1'b0;
				weight_mem[pos][col] = v;
				return 1'b1;
			end
			KIND_ELEM: begin
				if (pos >= ndepth)
					return 1'b0;
				// accumulate into every active column, wrapping at the sum width
				for (int j = 0; j < ncols; j++)
					col_sums[j] = col_sums[j] + sum_t'(v) * sum_t'(weight_mem[pos][j]);
				if (pos != ndepth - 1)
					return 1'b1;
				// close the row: saturate, look up, emit in column order
				for (int j = 0; j < ncols; j++) begin
					if (col_sums[j] > SAT_HI)
						sat = int'(SAT_HI);
					else if (col_sums[j] < SAT_LO)
						sat = int'(SAT_LO);
					else
						sat = int'(col_sums[j]);
					slot = 8'(sat + TBL_OFS);
					pending_activations.push_back('{row: 6'(row_ctr), col: 6'(j),
						val: act_table[slot], last: (j == ncols - 1)});
				end
				for (int j = 0; j < MAX_COLS; j++)
					col_sums[j] = '0;
				row_ctr = (row_ctr + 1 >= nrows) ? 0 : row_ctr + 1;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Drop the input valid if it is still held from the last transaction
	task automatic drop_input_valid();
		if (in_held)
			in_valid <= 1'b0;
		in_held = 1'b0;
	endtask

	// Send one item in bursts with random gaps; enter and leave at a falling edge
	task automatic send_item(logic [1:0] k, logic [7:0] pos, logic [5:0] col,
			logic signed [7:0] v, logic has_exp = 1'b0,
			logic signed [7:0] exp_val = 8'sd0);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				drop_input_valid();
				repeat (gap) @(negedge clk);
			end
		end
		in_valid    <= 1'b1;
		in_held     = 1'b1;
		kind        <= k;
		row_pos     <= pos;
		col_pos     <= col;
		value       <= v;
		block_quiet = 1'b0;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (predict_activations(k, pos, col, v))
			effective_items++;
		// replace the prediction with the typed-in activation
		if (has_exp)
			pending_activations[pending_activations.size() - 1] =
				'{row: 6'd0, col: 6'd0, val: exp_val, last: 1'b1};
		burst_left--;
		@(negedge clk);
	endtask

	// Wait until every activation is out and the block has finished its last item
	task automatic wait_quiet();
		drop_input_valid();
		while (pending_activations.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		block_quiet = 1'b1;
	endtask

	task automatic write_reg(reg_idx_t idx, cfg_t data);
		if (!block_quiet)
			wait_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_ROWS:  rows_reg  = data;
			REG_COLS:  cols_reg  = data;
			REG_DEPTH: depth_reg = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Ignored items: the unused kind or an element past the row depth
	task automatic send_noise(int ndepth);
		if ($urandom_range(0, 1))
			send_item(KIND_NONE, 8'($urandom), 6'($urandom), pick_value(VAL_FULL));
		else
			send_item(KIND_ELEM, 8'($urandom_range(ndepth, 255)), 6'($urandom),
				pick_value(VAL_FULL));
	endtask

	// Receiver: ready pattern switches among four random stall modes
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ($urandom_range(0, 3) != 0);
			2:       out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((stall_left % 5) < 2);
		endcase
	end

	// Check each output transaction against the oldest predicted activation
	always @(posedge clk) begin
		lut_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_activations.size() == 0) begin
				$error("unexpected result: row_index %0d col_index %0d out_value %0d last %0d",
					row_index, col_index, out_value, last);
				fail_count++;
			end else begin
				want = pending_activations.pop_front();
				if (row_index !== want.row) begin
					$error("row_index expected %0d actual %0d", want.row, row_index);
					fail_count++;
				end
				if (col_index !== want.col) begin
					$error("col_index expected %0d actual %0d", want.col, col_index);
					fail_count++;
				end
				if (out_value !== want.val) begin
					$error("out_value expected %0d actual %0d", want.val, out_value);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last expected %0d actual %0d", want.last, last);
					fail_count++;
				end
			end
		end
	end

	// Timeout
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("int8_matmul_saturate_lut_activation verification failed");
		$finish;
	end

	initial begin
		int        goal;
		int        phase;
		int        seqs;
		int        ndepth;
		int        nrows;
		int        ncols;
		int        p;
		int        order [$];
		bit        broken;
		val_mode_e vmode;

		for (int r = 0; r < MAX_DEPTH; r++)
			for (int c = 0; c < MAX_COLS; c++)
				weight_mem[r][c] = '0;
		for (int t = 0; t < 256; t++)
			act_table[t] = '0;
		for (int c = 0; c < MAX_COLS; c++)
			col_sums[c] = '0;

		// Hold reset, release at a falling edge
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Fill the whole table and weight store so no read ever hits an unwritten entry
		for (int t = 0; t < 256; t++)
			send_item(KIND_TBL, 8'(t), 6'($urandom), pick_value(VAL_FULL));
		for (int r = 0; r < MAX_DEPTH; r++)
			for (int c = 0; c < MAX_COLS; c++)
				send_item(KIND_WGT, 8'(r), 6'(c),
					$urandom_range(0, 1) ? pick_value(VAL_SMALL) : pick_value(VAL_FULL));

		// Walk the directed table
		for (int i = 0; i < DIR_STEPS; i++) begin
			if (directed[i].op == STEP_CFG)
				write_reg(directed[i].ridx, directed[i].rdata);
			else
				send_item(directed[i].knd, directed[i].pos, directed[i].col,
					directed[i].val, directed[i].has_exp, directed[i].exp_val);
		end

		// Sum overflow: 256 products of 2^14 at one position wrap the sums to zero
		write_reg(REG_ROWS, 7'd2);
		write_reg(REG_COLS, 7'd3);
		write_reg(REG_DEPTH, 7'd2);
		for (int c = 0; c < 3; c++)
			send_item(KIND_WGT, 8'd0, 6'(c), -8'sd128);
		repeat (WRAP_REPEATS)
			send_item(KIND_ELEM, 8'd0, 6'($urandom), -8'sd128);
		send_item(KIND_ELEM, 8'd1, 6'($urandom), 8'sd0);

		// Phases: three fixed corner settings, then random ones, each followed by a few sequences of items
		goal  = effective_items + ITEM_GOAL;
		phase = 0;
		while (effective_items < goal) begin
			case (phase)
				0: begin
					nrows = 64;
					ncols = 64;
					ndepth = 64;
				end
				1: begin
					nrows = 127;
					ncols = 1;
					ndepth = 0;
				end
				2: begin
					nrows = 0;
					ncols = 127;
					ndepth = 2;
				end
				default: begin
					nrows  = $urandom_range(1, 6);
					ncols  = $urandom_range(1, 8);
					ndepth = $urandom_range(1, 6);
					case ($urandom_range(0, 11))
						0:       nrows  = $urandom_range(0, 127);
						1:       ncols  = $urandom_range(0, 127);
						2:       ndepth = $urandom_range(0, 127);
						default: ;
					endcase
				end
			endcase
			write_reg(REG_ROWS, cfg_t'(nrows));
			write_reg(REG_COLS, cfg_t'(ncols));
			write_reg(REG_DEPTH, cfg_t'(ndepth));
			seqs = (phase == 0) ? 1 : $urandom_range(1, 4);
			phase++;

			repeat (seqs) begin
				ndepth = clamp_cfg(depth_reg, MAX_DEPTH);
				case ($urandom_range(0, 9))
					6: begin
						// rewrite weights, some outside the store
						repeat ($urandom_range(1, 6))
							send_item(KIND_WGT, ($urandom_range(0, 3) == 0)
								? 8'($urandom_range(MAX_DEPTH, 255))
								: 8'($urandom_range(0, MAX_DEPTH - 1)),
								6'($urandom), pick_value(VAL_FULL));
					end
					7: begin
						repeat ($urandom_range(1, 6))
							send_item(KIND_TBL, 8'($urandom), 6'($urandom),
								pick_value(VAL_FULL));
					end
					8: begin
						repeat ($urandom_range(1, 4))
							send_noise(ndepth);
					end
					9: begin
						// loose elements at random positions; may close early
						repeat ($urandom_range(1, ndepth))
							send_item(KIND_ELEM, 8'($urandom_range(0, ndepth - 1)),
								6'($urandom), pick_value(val_mode_e'($urandom_range(0, 2))));
					end
					default: begin
						// well-formed row in shuffled order, sometimes with gaps or repeats
						vmode  = val_mode_e'($urandom_range(0, 2));
						broken = ($urandom_range(0, 7) == 0);
						order.delete();
						for (p = 0; p < ndepth - 1; p++) begin
							order.push_back(p);
							if (broken && $urandom_range(0, 2) == 0)
								order.push_back(p);
						end
						order.shuffle();
						if (broken && order.size() > 0 && $urandom_range(0, 1))
							void'(order.pop_front());
						foreach (order[q]) begin
							if ($urandom_range(0, 9) == 0)
								send_noise(ndepth);
							send_item(KIND_ELEM, 8'(order[q]), 6'($urandom),
								pick_value(vmode));
						end
						send_item(KIND_ELEM, 8'(ndepth - 1), 6'($urandom), pick_value(vmode));
					end
				endcase
			end
		end

		// Drain and report
		wait_quiet();
		if (fail_count == 0)
			$display("int8_matmul_saturate_lut_activation verification clean");
		else
			$display("int8_matmul_saturate_lut_activation verification failed");
		$finish;
	end

endmodule
